/* rtl/nsr_pkg.sv */
// Package for the Newton square root block: word sizes, register indexes,
// status codes, controller states and the command and status structs.
// No dependencies.
`default_nettype none
package nsr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int STEP_BITS = 6;
  localparam int TOL_BITS  = 5;
  localparam int STAT_BITS = 2;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int DVD_BITS  = (PROD_BITS > WORD_BITS + FRAC_BITS) ?
                             PROD_BITS : WORD_BITS + FRAC_BITS;
  localparam int HI_BITS   = DVD_BITS - WORD_BITS;
  localparam int CMP_BITS  = (HI_BITS > WORD_BITS + 1) ? HI_BITS : WORD_BITS + 1;
  localparam int DIFF_BITS = (WORD_BITS > FRAC_BITS) ? WORD_BITS : FRAC_BITS + 1;
  localparam int DCNT_BITS = $clog2(WORD_BITS);

  localparam logic [DIFF_BITS-1:0] DIFF_ONE = DIFF_BITS'(1) << FRAC_BITS;

  localparam int CFG_DATA_BITS = STEP_BITS;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_STEPS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOL_SHIFT = 1'd1;

  localparam logic [STEP_BITS-1:0] MAX_STEPS_RST = 6'd40;
  localparam logic [TOL_BITS-1:0]  TOL_SHIFT_RST = 5'd16;

  localparam logic [STAT_BITS-1:0] ST_CONVERGED = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_LIMIT     = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_ZERO      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SQUARE,
    S_PREP,
    S_RANGE,
    S_DIV,
    S_UPDATE,
    S_DONE
  } nsr_state_t;

  typedef struct packed {
    logic                 load;
    logic                 set_code;
    logic [STAT_BITS-1:0] code;
    logic                 square;
    logic                 prep;
    logic                 range;
    logic                 div_step;
    logic                 update;
    logic                 finish;
  } nsr_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic converged;
    logic x_zero;
    logic div_ovf;
    logic div_done;
  } nsr_stat_t;

endpackage
`default_nettype wire

/* rtl/nsr_in_if.sv */
// Input channel of the Newton square root block: radicand and first guess.
// Depends on nsr_pkg.
`default_nettype none
interface nsr_in_if import nsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] radicand;
  logic [WORD_BITS-1:0] first_guess;

  modport source (output valid, output radicand, output first_guess, input ready);
  modport sink   (input valid, input radicand, input first_guess, output ready);
endinterface
`default_nettype wire

/* rtl/nsr_out_if.sv */
// Result channel of the Newton square root block: root, step count, status.
// Depends on nsr_pkg.
`default_nettype none
interface nsr_out_if import nsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] root;
  logic [STEP_BITS-1:0] steps_taken;
  logic [STAT_BITS-1:0] status;

  modport source (output valid, output root, output steps_taken, output status,
                  input ready);
  modport sink   (input valid, input root, input steps_taken, input status,
                  output ready);
endinterface
`default_nettype wire

/* rtl/nsr_ctrl.sv */
// Controller of the Newton square root block: sequences load, square, divide
// and update for each step, and owns the result valid flag. Depends on nsr_pkg.
`default_nettype none
module nsr_ctrl import nsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire nsr_stat_t stat,
  output nsr_cmd_t       cmd
);

  nsr_state_t state_r;
  nsr_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.at_limit || stat.converged || stat.x_zero) state_nxt = S_DONE;
        else state_nxt = S_SQUARE;
      end
      S_SQUARE: state_nxt = S_PREP;
      S_PREP:   state_nxt = S_RANGE;
      S_RANGE:  state_nxt = S_DIV;
      S_DIV: begin
        if (stat.div_ovf || stat.div_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: state_nxt = S_CHECK;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.set_code = 1'b1;
        if (stat.at_limit) cmd.code = ST_LIMIT;
        else if (stat.converged) cmd.code = ST_CONVERGED;
        else cmd.code = ST_ZERO;
      end
      S_SQUARE: cmd.square = 1'b1;
      S_PREP:   cmd.prep = 1'b1;
      S_RANGE:  cmd.range = 1'b1;
      S_DIV:    cmd.div_step = !stat.div_ovf;
      S_UPDATE: cmd.update = 1'b1;
      S_DONE:   cmd.finish = !out_valid_r || out_ready;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result valid rose outside the done state");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && stat.div_done |=> (state_r == S_UPDATE))
    else $error("division did not hand over to the update");

endmodule
`default_nettype wire

/* rtl/nsr_dp.sv */
// Datapath of the Newton square root block: estimate and step registers,
// the squaring multiplier, a radix-2 restoring divider and the result
// register. Depends on nsr_pkg.
`default_nettype none
module nsr_dp import nsr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nsr_cmd_t             cmd,
  output nsr_stat_t                 stat,
  input  wire logic [WORD_BITS-1:0] radicand,
  input  wire logic [WORD_BITS-1:0] first_guess,
  input  wire logic [STEP_BITS-1:0] max_steps,
  input  wire logic [TOL_BITS-1:0]  tol_shift,
  output logic [WORD_BITS-1:0]      root,
  output logic [STEP_BITS-1:0]      steps_taken,
  output logic [STAT_BITS-1:0]      status
);

  logic [WORD_BITS-1:0] x_r;
  logic [WORD_BITS-1:0] n_r;
  logic [DIFF_BITS-1:0] diff_r;
  logic [STEP_BITS-1:0] count_r;
  logic [PROD_BITS-1:0] sq_r;
  logic [DVD_BITS-1:0]  mag_r;
  logic                 ge_r;
  logic                 ovf_r;
  logic [WORD_BITS:0]   rem_r;
  logic [WORD_BITS-1:0] q_r;
  logic [DCNT_BITS-1:0] div_cnt_r;
  logic [STAT_BITS-1:0] code_r;
  logic [WORD_BITS-1:0] root_r;
  logic [STEP_BITS-1:0] steps_r;
  logic [STAT_BITS-1:0] status_r;

  logic [PROD_BITS-1:0] sq_full;
  logic [DVD_BITS-1:0]  target;
  logic [DVD_BITS-1:0]  sq_ext;
  logic                 sq_ge;
  logic [WORD_BITS:0]   dvs;
  logic [CMP_BITS-1:0]  hi_ext;
  logic                 range_ovf;
  logic [WORD_BITS+1:0] trial;
  logic [WORD_BITS+1:0] trial_sub;
  logic                 trial_ge;
  logic [WORD_BITS:0]   sum;
  logic                 sat;
  logic [WORD_BITS-1:0] x_upd;
  logic [WORD_BITS-1:0] chg;

  assign sq_full   = x_r * x_r;
  assign target    = DVD_BITS'(n_r) << FRAC_BITS;
  assign sq_ext    = DVD_BITS'(sq_r);
  assign sq_ge     = sq_ext >= target;
  assign dvs       = {x_r, 1'b0};
  assign hi_ext    = CMP_BITS'(mag_r[DVD_BITS-1 -: HI_BITS]);
  assign range_ovf = !ge_r && (hi_ext >= CMP_BITS'(dvs));
  assign trial     = {rem_r, q_r[WORD_BITS-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign trial_ge  = trial >= {1'b0, dvs};
  assign sum       = {1'b0, x_r} + {1'b0, q_r};
  assign sat       = ovf_r || sum[WORD_BITS];

  // A growing step that leaves the word saturates; the change is then
  // measured against all ones.
  always_comb begin
    if (ge_r) begin
      x_upd = x_r - q_r;
      chg   = q_r;
    end else if (sat) begin
      x_upd = '1;
      chg   = ~x_r;
    end else begin
      x_upd = sum[WORD_BITS-1:0];
      chg   = q_r;
    end
  end

  assign stat.at_limit  = count_r >= max_steps;
  assign stat.converged = diff_r < (DIFF_BITS'(x_r) >> tol_shift);
  assign stat.x_zero    = x_r == '0;
  assign stat.div_ovf   = ovf_r;
  assign stat.div_done  = div_cnt_r == DCNT_BITS'(WORD_BITS - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= first_guess;
      n_r     <= radicand;
      diff_r  <= DIFF_ONE;
      count_r <= '0;
    end else if (cmd.update) begin
      x_r     <= x_upd;
      diff_r  <= DIFF_BITS'(chg);
      count_r <= count_r + 1'b1;
    end
    if (cmd.set_code) code_r <= cmd.code;
    if (cmd.square) sq_r <= sq_full;
    if (cmd.prep) begin
      ge_r  <= sq_ge;
      mag_r <= sq_ge ? (sq_ext - target) : (target - sq_ext);
    end
    if (cmd.range) begin
      ovf_r     <= range_ovf;
      rem_r     <= hi_ext[WORD_BITS:0];
      q_r       <= mag_r[WORD_BITS-1:0];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= trial_ge ? trial_sub[WORD_BITS:0] : trial[WORD_BITS:0];
      q_r       <= {q_r[WORD_BITS-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.finish) begin
      root_r   <= x_r;
      steps_r  <= count_r;
      status_r <= code_r;
    end
  end

  assign root        = root_r;
  assign steps_taken = steps_r;
  assign status      = status_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < dvs))
    else $error("divider remainder not below divisor");

  a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && ge_r |=> (x_r <= $past(x_r)))
    else $error("shrinking step raised the estimate");

endmodule
`default_nettype wire

/* rtl/newton_square_root.sv */
// Top level of the Newton square root block: configuration registers,
// controller and datapath. Depends on nsr_pkg, nsr_in_if, nsr_out_if,
// nsr_ctrl and nsr_dp.
//
//   channel  direction  payload                          handshake
//   in_ch    in         radicand, first_guess            valid/ready
//   out_ch   out        root, steps_taken, status        valid/ready
//   cfg_*    in         cfg_idx, cfg_data                cfg_we
//
// A Newton step runs square, difference, range check, the divider steps,
// update and stop test in that order. A growing step whose quotient leaves
// the word skips the divider steps. Reset is synchronous and active low.
// A new word is taken while the last result still waits; only the final
// hand-over stalls on the result channel.
`default_nettype none
module newton_square_root import nsr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  nsr_in_if.sink                        in_ch,
  nsr_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [STEP_BITS-1:0] max_steps_r;
  logic [TOL_BITS-1:0]  tol_shift_r;
  nsr_cmd_t             cmd;
  nsr_stat_t            stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= MAX_STEPS_RST;
      tol_shift_r <= TOL_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_STEPS: max_steps_r <= cfg_data[STEP_BITS-1:0];
        CFG_TOL_SHIFT: tol_shift_r <= cfg_data[TOL_BITS-1:0];
        default: begin
          max_steps_r <= max_steps_r;
        end
      endcase
    end
  end

  nsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nsr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .radicand    (in_ch.radicand),
    .first_guess (in_ch.first_guess),
    .max_steps   (max_steps_r),
    .tol_shift   (tol_shift_r),
    .root        (out_ch.root),
    .steps_taken (out_ch.steps_taken),
    .status      (out_ch.status)
  );

endmodule
`default_nettype wire

/* verif/newton_square_root_tb.sv */
// Self-checking testbench for newton_square_root: drives radicand and guess
// words, predicts root, step count and status per word, checks every result.
// Depends on nsr_pkg, nsr_in_if, nsr_out_if and the newton_square_root RTL.
`default_nettype none
module newton_square_root_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsr_pkg::*;

  localparam logic [63:0] WORD_MAX = (64'd1 << WORD_BITS) - 64'd1;

  typedef struct packed {
    logic [WORD_BITS-1:0] radicand;
    logic [WORD_BITS-1:0] first_guess;
  } root_query_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] root;
    logic [STEP_BITS-1:0] steps_taken;
    logic [STAT_BITS-1:0] status;
  } root_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  nsr_in_if  in_ch ();
  nsr_out_if out_ch ();

  newton_square_root i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  root_query_t  pending_queries[$];
  root_result_t expected_roots[$];
  logic [STEP_BITS-1:0] steps_cfg = MAX_STEPS_RST;
  logic [TOL_BITS-1:0]  tol_cfg   = TOL_SHIFT_RST;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned mismatch_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic root_result_t solve_root(input logic [WORD_BITS-1:0] radicand,
                                              input logic [WORD_BITS-1:0] guess,
                                              input logic [STEP_BITS-1:0] step_limit,
                                              input logic [TOL_BITS-1:0]  tol);
    logic [63:0] x;
    logic [63:0] nxt;
    logic [63:0] sq;
    logic [63:0] target;
    logic [63:0] twice;
    logic [63:0] change;
    int unsigned count;
    logic [STAT_BITS-1:0] stat;
    root_result_t res;
    x      = {32'd0, guess};
    change = 64'd1 << FRAC_BITS;
    count  = 0;
    stat   = ST_LIMIT;
    while (count < step_limit) begin
      if (change < (x >> tol)) begin
        stat = ST_CONVERGED;
        break;
      end
      if (x == 64'd0) begin
        stat = ST_ZERO;
        break;
      end
      sq     = x * x;
      target = {32'd0, radicand} << FRAC_BITS;
      twice  = x << 1;
      if (sq >= target) begin
        nxt = x - (sq - target) / twice;
      end else begin
        nxt = x + (target - sq) / twice;
        if (nxt > WORD_MAX) nxt = WORD_MAX;
      end
      change = (x >= nxt) ? (x - nxt) : (nxt - x);
      x = nxt;
      count++;
    end
    res.root        = x[WORD_BITS-1:0];
    res.steps_taken = count[STEP_BITS-1:0];
    res.status      = stat;
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic root_query_t make_query();
    root_query_t q;
    int unsigned kind;
    int unsigned width;
    int unsigned spread;
    logic [63:0] mask;
    longint g;
    longint offset;
    real r;
    kind  = $urandom_range(0, 99);
    width = $urandom_range(1, WORD_BITS);
    mask  = (64'd1 << width) - 64'd1;
    q.radicand    = $urandom & mask[WORD_BITS-1:0];
    q.first_guess = $urandom;
    if (kind < 45) begin
      r      = $sqrt(real'(q.radicand) * 65536.0);
      spread = $urandom_range(0, 20);
      offset = longint'($urandom_range(0, (1 << spread) - 1));
      g      = longint'(r);
      if ($urandom_range(0, 1) == 1) g = g - offset;
      else g = g + offset;
      if (g < 0) g = 0;
      if (g > longint'(WORD_MAX)) g = longint'(WORD_MAX);
      q.first_guess = g[WORD_BITS-1:0];
    end else if (kind < 65) begin
      q.radicand = $urandom;
    end else if (kind < 78) begin
      q.first_guess = $urandom_range(1, 255);
    end else if (kind < 86) begin
      q.first_guess = '0;
    end else begin
      q.radicand    = edge_value();
      q.first_guess = edge_value();
    end
    return q;
  endfunction

  always @(posedge clk) begin : drive_queries
    root_query_t q;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_roots.push_back(solve_root(in_ch.radicand, in_ch.first_guess,
                                            steps_cfg, tol_cfg));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_queries.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          q = pending_queries.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.radicand    <= q.radicand;
          in_ch.first_guess <= q.first_guess;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_roots
    root_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_roots.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result word: root %h steps %0d status %0d",
                     out_ch.root, out_ch.steps_taken, out_ch.status);
        end else begin
          want = expected_roots.pop_front();
          if (out_ch.root !== want.root || out_ch.steps_taken !== want.steps_taken ||
              out_ch.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected root %h steps %0d status %0d, got root %h steps %0d status %0d",
                       want.root, want.steps_taken, want.status,
                       out_ch.root, out_ch.steps_taken, out_ch.status);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_STEPS) steps_cfg = data[STEP_BITS-1:0];
    else tol_cfg = data[TOL_BITS-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_queries.size() != 0 || in_ch.valid || expected_roots.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] step_data,
                           input logic [CFG_DATA_BITS-1:0] tol_data,
                           input int unsigned count,
                           input int unsigned send_idle,
                           input int unsigned recv_idle);
    write_reg(CFG_MAX_STEPS, step_data);
    write_reg(CFG_TOL_SHIFT, tol_data);
    in_idle_pct  = send_idle;
    out_idle_pct = recv_idle;
    repeat (count) pending_queries.push_back(make_query());
    wait_idle();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_MAX_STEPS;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.radicand    = '0;
    in_ch.first_guess = '0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes, exact roots, overflow and zero estimates.
    in_idle_pct  = 35;
    out_idle_pct = 71;
    pending_queries.push_back('{32'h0000_0000, 32'h0000_0000});
    pending_queries.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_queries.push_back('{32'hFFFF_FFFF, 32'h0000_0001});
    pending_queries.push_back('{32'h0000_0000, 32'hFFFF_FFFF});
    pending_queries.push_back('{32'h0000_0001, 32'h0000_0001});
    pending_queries.push_back('{32'h0004_0000, 32'h0002_0000});
    pending_queries.push_back('{32'h0004_0000, 32'h0001_0000});
    pending_queries.push_back('{32'h0002_0000, 32'h0001_0000});
    pending_queries.push_back('{32'h0000_0100, 32'h0000_0100});
    pending_queries.push_back('{32'h1000_0000, 32'h7FFF_FFFF});
    pending_queries.push_back('{32'h1234_5678, 32'h0000_ABCD});
    pending_queries.push_back('{32'h0001_0000, 32'h0000_0000});
    pending_queries.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
    pending_queries.push_back('{32'h8000_0000, 32'h8000_0000});
    pending_queries.push_back('{32'h5555_5555, 32'hAAAA_AAAA});
    pending_queries.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
    wait_idle();

    run_phase(6'd12, 6'd10, 70, 35, 71);
    run_phase(6'd1,  6'd0,  60, 35, 71);
    run_phase(6'd63, 6'd31, 15, 71, 35);
    run_phase(6'd63, 6'd0,  50, 71, 35);
    run_phase(6'd0,  6'h3F, 25, 71, 35);
    run_phase(6'd8,  6'd20, 80, 0, 0);
    run_phase(6'd40, 6'd16, 80, 0, 0);
    run_phase(6'd25, 6'd12, 80, 0, 0);

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
